FILE: rtl/dezm_pkg.sv
// Shared types, constants and tables for the dual-energy effective-Z mapper.
`default_nettype none
package dezm_pkg;

  // Defaults for the top-level parameter and the configuration registers
  localparam int unsigned MaxRowsDefault = 256;
  localparam int unsigned DetsReset      = 139;
  localparam int unsigned SlicesReset    = 216;

  // Queue between the front and the back engine
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Ratio and Z limits
  localparam logic [14:0] FallbackQ14 = 15'd164;
  localparam logic [14:0] LimitQ14    = 15'd24576;
  localparam logic [14:0] ZCapQ8      = 15'd25600;
  // Largest ratio that takes the power-law fit, and the first quadratic fit
  localparam logic [14:0] PowBound    = 15'd9830;
  localparam logic [14:0] QuadBound   = 15'd18022;

  // Fit coefficients (Q16 for the quadratics)
  localparam logic [30:0] TScale  = 31'd219039;
  localparam logic [30:0] ZScale  = 31'd11380;
  localparam logic [30:0] QuadALo = 31'd4722288;
  localparam logic [30:0] QuadBLo = 31'd2107597;
  localparam logic [30:0] QuadCLo = 31'd151744;
  localparam logic [30:0] QuadAHi = 31'd138848321;
  localparam logic [30:0] QuadBHi = 31'd296486876;
  localparam logic [30:0] QuadCHi = 31'd161684135;

  // Log2 offsets in Q16
  localparam logic [20:0] Log16Q16 = 21'd1048576;
  localparam logic [19:0] Log14Q16 = 20'd917504;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DETS   = 1'b0,
    CFG_SLICES = 1'b1
  } cfg_idx_e;

  // Input request
  typedef struct packed {
    logic [16:0] trans_low;
    logic [16:0] trans_high;
  } in_t;

  // Result request
  typedef struct packed {
    logic [14:0] ratio_value;
    logic [14:0] zeff_value;
    logic [15:0] pixel_column;
    logic [7:0]  pixel_row;
    logic        last_in_run;
  } res_t;

  // Pixel handed from the front to the back engine
  typedef struct packed {
    logic [16:0] lo;
    logic [16:0] hi;
    logic [15:0] col;
    logic [7:0]  row;
    logic        last;
  } pix_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EXEC,
    FS_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_LOG_INIT,
    BS_LOG_ITER,
    BS_DIV,
    BS_RATIO,
    BS_ZSEL,
    BS_POW_T,
    BS_POW_EXP,
    BS_POW_MUL,
    BS_POW_FIN,
    BS_QUAD_SQ,
    BS_QUAD_A,
    BS_QUAD_B,
    BS_QUAD_FIN,
    BS_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    LOG_LO,
    LOG_HI,
    LOG_Q
  } log_sel_e;

  // Factors 2^(-2^-i) in Q1.30, entry 0 is one half
  typedef logic [16:0][30:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    v     = v_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bit_v > v) bit_v = bit_v >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v   = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] prev;
    prev   = 64'd1 << 29;
    tab[0] = prev[30:0];
    for (int i = 1; i <= 16; i++) begin
      prev   = isqrt64(prev << 30);
      tab[i] = prev[30:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage
`default_nettype wire

FILE: rtl/dual_energy_zeff_map.sv
// Front: a request is taken in idle, processed in execute, and the pixels it
// completes are queued one at a time in push. The back engine takes a new pixel
// only after handing out its last result; it runs on one shared 31x31 multiplier
// (serial log2 squaring, exponent steps) and a 35-step restoring divider.
// Reset: counters and control clear at once, registers return to 139 rows and
// 216 columns; column buffers are not cleared and hold data only once written.
`default_nettype none
module dual_energy_zeff_map #(
  parameter int unsigned MAX_ROWS = dezm_pkg::MaxRowsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [0:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  input  wire dezm_pkg::in_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output dezm_pkg::res_t      out_data_o,
  input  wire logic           out_stall_i
);

  logic [8:0]     dets_q;
  logic [15:0]    slices_q;
  logic           q_push_valid;
  dezm_pkg::pix_t q_push_data;
  logic           q_full;
  logic           q_pop;
  dezm_pkg::pix_t q_pop_data;
  logic           q_empty;
  logic           in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dets_q   <= 9'(dezm_pkg::DetsReset);
      slices_q <= 16'(dezm_pkg::SlicesReset);
    end else if (cfg_we_i) begin
      unique case (dezm_pkg::cfg_idx_e'(cfg_index_i))
        dezm_pkg::CFG_DETS:   dets_q   <= cfg_data_i[8:0];
        dezm_pkg::CFG_SLICES: slices_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dezm_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dets_i      (dets_q),
    .slices_i    (slices_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .push_valid_o(q_push_valid),
    .push_data_o (q_push_data),
    .push_full_i (q_full)
  );

  dezm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  dezm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .pop_data_i (q_pop_data),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  // Front goes busy after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> in_stall_o)
    else $error("front did not hold off after accepting a request");

  // Queue level is consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // Back engine does not take a pixel while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !q_pop)
    else $error("back engine popped while presenting a result");

endmodule
`default_nettype wire

FILE: rtl/dezm_front.sv
// Front: position counters, two column buffers and zero-pixel neighbor fill.
`default_nettype none
module dezm_front #(
  parameter int unsigned MAX_ROWS = dezm_pkg::MaxRowsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [8:0]    dets_i,
  input  wire logic [15:0]   slices_i,
  input  wire logic          in_valid_i,
  input  wire dezm_pkg::in_t in_data_i,
  output logic               in_stall_o,
  output logic               push_valid_o,
  output dezm_pkg::pix_t     push_data_o,
  input  wire logic          push_full_i
);

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DW   = (RowW + 1 > 9) ? RowW + 1 : 9;

  dezm_pkg::front_state_e state_q, state_d;

  logic [RowW-1:0] row_q;
  logic [15:0]     col_q;
  logic [16:0]     lo_q, hi_q;
  logic [33:0]     prev_mid_q;
  logic [33:0]     col1_rd_a_q, col1_rd_b_q, col2_rd_q;
  dezm_pkg::pix_t  ent0_q, ent1_q;
  logic            v0_q, v1_q;

  logic [33:0] col1_mem [MAX_ROWS];
  logic [33:0] col2_mem [MAX_ROWS];

  logic            accept;
  logic            exec;
  logic            push_done;
  logic [RowW-1:0] row_nx;
  logic [DW-1:0]   dets_w, d_eff, row_p1;
  logic [16:0]     s_eff, col_p1;
  logic            last_col, row_end, fill_en;
  logic [RowW+7:0] row_wide;
  logic [16:0]     cl, ch, cl_f, ch_f;
  logic [18:0]     sum_lo, sum_hi;
  dezm_pkg::pix_t  ent0_d, ent1_d;

  assign accept    = in_valid_i && !in_stall_o;
  assign exec      = (state_q == dezm_pkg::FS_EXEC);
  assign push_done = push_valid_o && !push_full_i;
  assign row_nx    = row_q + RowW'(1);

  // Effective bounds
  assign dets_w = DW'(dets_i);
  assign d_eff  = (dets_w == '0) ? DW'(1) :
                  (dets_w > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : dets_w;
  assign s_eff  = (slices_i == '0) ? 17'd1 : {1'b0, slices_i};
  assign col_p1 = {1'b0, col_q} + 17'd1;
  assign row_p1 = DW'(row_q) + DW'(1);

  assign last_col = col_p1 >= s_eff;
  assign row_end  = row_p1 >= d_eff;
  assign fill_en  = (col_q >= 16'd2) && (row_q != '0) && !row_end;
  assign row_wide = {8'b0, row_q};

  // Neighbor fill: up is the raw pixel read one row earlier
  assign cl     = col1_rd_a_q[16:0];
  assign ch     = col1_rd_a_q[33:17];
  assign sum_lo = 19'(prev_mid_q[16:0]) + 19'(col1_rd_b_q[16:0])
                + 19'(col2_rd_q[16:0]) + 19'(lo_q);
  assign sum_hi = 19'(prev_mid_q[33:17]) + 19'(col1_rd_b_q[33:17])
                + 19'(col2_rd_q[33:17]) + 19'(hi_q);
  assign cl_f   = (fill_en && cl == '0) ? sum_lo[18:2] : cl;
  assign ch_f   = (fill_en && cl != '0 && ch == '0) ? sum_hi[18:2] : ch;

  always_comb begin
    ent0_d.lo   = cl_f;
    ent0_d.hi   = ch_f;
    ent0_d.col  = col_q - 16'd1;
    ent0_d.row  = row_wide[7:0];
    ent0_d.last = !last_col;
    ent1_d.lo   = lo_q;
    ent1_d.hi   = hi_q;
    ent1_d.col  = col_q;
    ent1_d.row  = row_wide[7:0];
    ent1_d.last = 1'b1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dezm_pkg::FS_IDLE: if (accept) state_d = dezm_pkg::FS_EXEC;
      dezm_pkg::FS_EXEC: begin
        state_d = ((col_q != '0) || last_col) ? dezm_pkg::FS_PUSH : dezm_pkg::FS_IDLE;
      end
      dezm_pkg::FS_PUSH: begin
        if (push_done && !(v0_q && v1_q)) state_d = dezm_pkg::FS_IDLE;
      end
      default: state_d = dezm_pkg::FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o   = 1'b1;
    push_valid_o = 1'b0;
    push_data_o  = v0_q ? ent0_q : ent1_q;
    unique case (state_q)
      dezm_pkg::FS_IDLE: in_stall_o = 1'b0;
      dezm_pkg::FS_PUSH: push_valid_o = v0_q || v1_q;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dezm_pkg::FS_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        v0_q <= (col_q != '0);
        v1_q <= last_col;
        // Advance position
        if (row_end) begin
          row_q <= '0;
          col_q <= last_col ? 16'd0 : col_p1[15:0];
        end else begin
          row_q <= row_nx;
        end
      end else if (push_done) begin
        if (v0_q) v0_q <= 1'b0;
        else      v1_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q <= in_data_i.trans_low;
      hi_q <= in_data_i.trans_high;
    end
    if (exec) begin
      prev_mid_q <= col1_rd_a_q;
      ent0_q     <= ent0_d;
      ent1_q     <= ent1_d;
    end
  end

  // Column buffers: shift the current row one column back
  always_ff @(posedge clk_i) begin
    if (exec) begin
      col2_mem[row_q] <= col1_rd_a_q;
      col1_mem[row_q] <= {hi_q, lo_q};
    end
    col1_rd_a_q <= col1_mem[row_q];
    col1_rd_b_q <= col1_mem[row_nx];
    col2_rd_q   <= col2_mem[row_q];
  end

endmodule
`default_nettype wire

FILE: rtl/dezm_queue.sv
// Short pixel queue between the front and the back engine.
`default_nettype none
module dezm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  input  wire dezm_pkg::pix_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output dezm_pkg::pix_t      pop_data_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = dezm_pkg::QueuePtrW;

  dezm_pkg::pix_t entries_q [dezm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push;
  logic            pop;

  assign full_o     = (count_q == (PtrW + 1)'(dezm_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign push       = push_valid_i && !full_o;
  assign pop        = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop)      count_q <= count_q + (PtrW + 1)'(1);
      else if (pop && !push) count_q <= count_q - (PtrW + 1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

FILE: rtl/dezm_back.sv
// Back engine: log ratio and effective-Z fit on one shared multiplier.
`default_nettype none
module dezm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire dezm_pkg::pix_t pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output dezm_pkg::res_t      out_data_o,
  input  wire logic           out_stall_i
);

  dezm_pkg::back_state_e state_q, state_d;
  dezm_pkg::log_sel_e    sel_q;
  dezm_pkg::pix_t        ent_q;

  logic [5:0]  cnt_q;
  logic [3:0]  e_q;
  logic [30:0] y_q;
  logic [15:0] frac_q;
  logic [20:0] nl_q;
  logic [34:0] num_q;
  logic [20:0] rem_q;
  logic [14:0] q_q;
  logic [19:0] l_q;
  logic [5:0]  tn_q;
  logic [15:0] tf_q;
  logic [30:0] p_q;
  logic [57:0] m_q;
  logic [58:0] pos_q;
  logic [57:0] neg_q;
  logic        quad_hi_q;
  logic [14:0] z_q;

  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;
  logic        fallback;
  logic [15:0] log_x;
  logic [3:0]  lead;
  logic [30:0] y_init;
  logic [31:0] sq_t;
  logic        sq_bit;
  logic [19:0] log_val;
  logic [20:0] n_val;
  logic        log_last;
  logic [21:0] trial;
  logic        trial_ge;
  logic [21:0] t_val;
  logic [59:0] pow_sum;
  logic [59:0] pow_sh;
  logic [58:0] quad_diff;
  logic [22:0] quad_z;
  logic [58:0] c_shift;

  assign prod = mul_a * mul_b;

  // Input checks on a popped pixel
  assign fallback = pop_data_i.lo[16] || pop_data_i.hi[16]
                 || (pop_data_i.lo == '0) || (pop_data_i.hi == '0);

  // Log2 operand, leading one and normalized mantissa
  always_comb begin
    unique case (sel_q)
      dezm_pkg::LOG_LO: log_x = ent_q.lo[15:0];
      dezm_pkg::LOG_HI: log_x = ent_q.hi[15:0];
      default:          log_x = {1'b0, q_q};
    endcase
    lead = '0;
    for (int k = 0; k < 16; k++) begin
      if (log_x[k]) lead = 4'(k);
    end
  end
  assign y_init = 31'(log_x) << (5'd30 - 5'(lead));

  // Squaring step
  assign sq_t     = prod[61:30];
  assign sq_bit   = sq_t[31];
  assign log_val  = {e_q, frac_q[14:0], sq_bit};
  assign n_val    = dezm_pkg::Log16Q16 - 21'(log_val);
  assign log_last = (cnt_q == 6'd15);

  // Restoring divide step
  assign trial    = {rem_q, num_q[34]};
  assign trial_ge = trial >= {1'b0, nl_q};

  // Power-law exponent and final scale
  assign t_val    = prod[37:16];
  assign pow_sum  = {2'b0, m_q} + (60'd1 << (6'd29 + tn_q));
  assign pow_sh   = pow_sum >> (6'd30 + tn_q);

  // Quadratic result
  assign c_shift   = 59'(quad_hi_q ? dezm_pkg::QuadCHi : dezm_pkg::QuadCLo) << 28;
  assign quad_diff = pos_q - {1'b0, neg_q} + (59'd1 << 35);
  assign quad_z    = quad_diff[58:36];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dezm_pkg::BS_IDLE: begin
        if (!empty_i) state_d = fallback ? dezm_pkg::BS_ZSEL : dezm_pkg::BS_LOG_INIT;
      end
      dezm_pkg::BS_LOG_INIT: state_d = dezm_pkg::BS_LOG_ITER;
      dezm_pkg::BS_LOG_ITER: begin
        if (log_last) begin
          unique case (sel_q)
            dezm_pkg::LOG_LO: state_d = dezm_pkg::BS_LOG_INIT;
            dezm_pkg::LOG_HI: state_d = dezm_pkg::BS_DIV;
            default:          state_d = dezm_pkg::BS_POW_T;
          endcase
        end
      end
      dezm_pkg::BS_DIV:   if (cnt_q == 6'd34) state_d = dezm_pkg::BS_RATIO;
      dezm_pkg::BS_RATIO: state_d = dezm_pkg::BS_ZSEL;
      dezm_pkg::BS_ZSEL: begin
        state_d = (q_q <= dezm_pkg::PowBound) ? dezm_pkg::BS_LOG_INIT
                                              : dezm_pkg::BS_QUAD_SQ;
      end
      dezm_pkg::BS_POW_T: begin
        state_d = (t_val[21:16] >= 6'd30) ? dezm_pkg::BS_OUT : dezm_pkg::BS_POW_EXP;
      end
      dezm_pkg::BS_POW_EXP:  if (cnt_q == 6'd16) state_d = dezm_pkg::BS_POW_MUL;
      dezm_pkg::BS_POW_MUL:  state_d = dezm_pkg::BS_POW_FIN;
      dezm_pkg::BS_POW_FIN:  state_d = dezm_pkg::BS_OUT;
      dezm_pkg::BS_QUAD_SQ:  state_d = dezm_pkg::BS_QUAD_A;
      dezm_pkg::BS_QUAD_A:   state_d = dezm_pkg::BS_QUAD_B;
      dezm_pkg::BS_QUAD_B:   state_d = dezm_pkg::BS_QUAD_FIN;
      dezm_pkg::BS_QUAD_FIN: state_d = dezm_pkg::BS_OUT;
      dezm_pkg::BS_OUT:      if (!out_stall_i) state_d = dezm_pkg::BS_IDLE;
      default:               state_d = dezm_pkg::BS_IDLE;
    endcase
  end

  // Outputs and multiplier operands
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      dezm_pkg::BS_IDLE:     pop_o = !empty_i;
      dezm_pkg::BS_LOG_ITER: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      dezm_pkg::BS_POW_T: begin
        mul_a = 31'(l_q);
        mul_b = dezm_pkg::TScale;
      end
      dezm_pkg::BS_POW_EXP: begin
        mul_a = p_q;
        mul_b = dezm_pkg::ExpTab[cnt_q[4:0]];
      end
      dezm_pkg::BS_POW_MUL: begin
        mul_a = p_q;
        mul_b = dezm_pkg::ZScale;
      end
      dezm_pkg::BS_QUAD_SQ: begin
        mul_a = 31'(q_q);
        mul_b = 31'(q_q);
      end
      dezm_pkg::BS_QUAD_A: begin
        mul_a = quad_hi_q ? dezm_pkg::QuadAHi : dezm_pkg::QuadALo;
        mul_b = m_q[30:0];
      end
      dezm_pkg::BS_QUAD_B: begin
        mul_a = quad_hi_q ? dezm_pkg::QuadBHi : dezm_pkg::QuadBLo;
        mul_b = 31'(q_q);
      end
      dezm_pkg::BS_OUT:      out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_data_o.ratio_value  = q_q;
    out_data_o.zeff_value   = z_q;
    out_data_o.pixel_column = ent_q.col;
    out_data_o.pixel_row    = ent_q.row;
    out_data_o.last_in_run  = ent_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dezm_pkg::BS_IDLE;
    else         state_q <= state_d;
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dezm_pkg::BS_IDLE: begin
        if (!empty_i) begin
          ent_q <= pop_data_i;
          sel_q <= dezm_pkg::LOG_LO;
          q_q   <= dezm_pkg::FallbackQ14;
        end
      end
      dezm_pkg::BS_LOG_INIT: begin
        y_q    <= y_init;
        e_q    <= lead;
        frac_q <= '0;
        cnt_q  <= '0;
      end
      dezm_pkg::BS_LOG_ITER: begin
        y_q    <= sq_bit ? sq_t[31:1] : sq_t[30:0];
        frac_q <= {frac_q[14:0], sq_bit};
        cnt_q  <= cnt_q + 6'd1;
        if (log_last) begin
          unique case (sel_q)
            dezm_pkg::LOG_LO: begin
              nl_q  <= n_val;
              sel_q <= dezm_pkg::LOG_HI;
            end
            dezm_pkg::LOG_HI: begin
              // Numerator with half-divisor rounding
              num_q <= {n_val, 14'b0} + 35'(nl_q >> 1);
              rem_q <= '0;
              cnt_q <= '0;
            end
            default: l_q <= dezm_pkg::Log14Q16 - log_val;
          endcase
        end
      end
      dezm_pkg::BS_DIV: begin
        rem_q <= trial_ge ? 21'(trial - {1'b0, nl_q}) : trial[20:0];
        num_q <= {num_q[33:0], trial_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      dezm_pkg::BS_RATIO: begin
        // Drop out-of-range ratios to the fallback
        if (num_q == '0 || num_q > 35'(dezm_pkg::LimitQ14)) q_q <= dezm_pkg::FallbackQ14;
        else                                                q_q <= num_q[14:0];
      end
      dezm_pkg::BS_ZSEL: begin
        sel_q     <= dezm_pkg::LOG_Q;
        quad_hi_q <= (q_q > dezm_pkg::QuadBound);
      end
      dezm_pkg::BS_POW_T: begin
        tn_q  <= t_val[21:16];
        tf_q  <= t_val[15:0];
        p_q   <= 31'd1 << 30;
        cnt_q <= 6'd1;
        z_q   <= '0;
      end
      dezm_pkg::BS_POW_EXP: begin
        if (tf_q[15]) p_q <= prod[60:30];
        tf_q  <= {tf_q[14:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
      end
      dezm_pkg::BS_POW_MUL: m_q <= prod[57:0];
      dezm_pkg::BS_POW_FIN: begin
        z_q <= (pow_sh > 60'(dezm_pkg::ZCapQ8)) ? dezm_pkg::ZCapQ8 : pow_sh[14:0];
      end
      dezm_pkg::BS_QUAD_SQ: m_q   <= prod[57:0];
      dezm_pkg::BS_QUAD_A:  pos_q <= {1'b0, prod[57:0]} + c_shift;
      dezm_pkg::BS_QUAD_B:  neg_q <= {prod[43:0], 14'b0};
      dezm_pkg::BS_QUAD_FIN: begin
        // Clamp negative sums to zero and cap the top
        if (pos_q <= {1'b0, neg_q})                 z_q <= '0;
        else if (quad_z > 23'(dezm_pkg::ZCapQ8))    z_q <= dezm_pkg::ZCapQ8;
        else                                        z_q <= quad_z[14:0];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
